FILE: hw/rtl/ghash_acc_pkg.sv
// ----------------------------------------------------------------------------
// ghash_acc_pkg
// Types, constants and the GF(2^128) multiply shared by the GHASH accumulator.
// ----------------------------------------------------------------------------
package ghash_acc_pkg;

   localparam int unsigned HALF_W   = 64;
   localparam int unsigned BLOCK_W  = 128;
   localparam int unsigned NBYTES   = 16;
   localparam int unsigned COUNT_W  = 5;
   localparam int unsigned CSR_IDX_W = 1;
   localparam int unsigned CSR_DATA_W = 64;

   // x^128 = x^7 + x^2 + x + 1, the 0xe1 constant in reflected order
   localparam int unsigned FOLD_SPAN = 7;

   typedef enum logic {
      OP_ABSORB = 1'b0,
      OP_CLEAR  = 1'b1
   } opcode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_SUBKEY_HIGH = 1'b0,
      REG_SUBKEY_LOW  = 1'b1
   } csr_index_type;

   typedef logic [BLOCK_W-1:0] block_type;

   // reduce a polynomial of degree below 134 modulo x^128 + x^7 + x^2 + x + 1
   function automatic logic [BLOCK_W-1:0] fold_bits(input logic [BLOCK_W+FOLD_SPAN-2:0] v);
      logic [BLOCK_W+FOLD_SPAN-2:0] r;
      r = v;
      r = r ^ {{BLOCK_W{1'b0}}, r[BLOCK_W+FOLD_SPAN-2:BLOCK_W]}
            ^ {{(BLOCK_W-1){1'b0}}, r[BLOCK_W+FOLD_SPAN-2:BLOCK_W], 1'b0}
            ^ {{(BLOCK_W-2){1'b0}}, r[BLOCK_W+FOLD_SPAN-2:BLOCK_W], 2'b0}
            ^ {{(BLOCK_W-FOLD_SPAN){1'b0}}, r[BLOCK_W+FOLD_SPAN-2:BLOCK_W], 7'b0};
      return r[BLOCK_W-1:0];
   endfunction

   // gcm multiply: bit 0 of the field element is the msb of byte 0
   function automatic block_type gf128_mul(input block_type a, input block_type b);
      logic [BLOCK_W-1:0]   ar;
      logic [BLOCK_W-1:0]   br;
      logic [2*BLOCK_W-2:0] prod;
      logic [BLOCK_W-2:0]   hi;
      logic [BLOCK_W+FOLD_SPAN-2:0] f;
      logic [BLOCK_W-1:0]   low;
      block_type            z;
      for (int i = 0; i < BLOCK_W; i++) begin
         ar[i] = a[BLOCK_W-1-i];
         br[i] = b[BLOCK_W-1-i];
      end
      prod = '0;
      for (int i = 0; i < BLOCK_W; i++) begin
         if (br[i]) begin
            prod = prod ^ ({{(BLOCK_W-1){1'b0}}, ar} << i);
         end
      end
      hi  = prod[2*BLOCK_W-2:BLOCK_W];
      f   = {{FOLD_SPAN{1'b0}}, hi}
            ^ {{(FOLD_SPAN-1){1'b0}}, hi, 1'b0}
            ^ {{(FOLD_SPAN-2){1'b0}}, hi, 2'b0}
            ^ {hi, 7'b0};
      low = prod[BLOCK_W-1:0] ^ fold_bits({{(FOLD_SPAN-1){1'b0}}, f[BLOCK_W-1:0]})
            ^ fold_bits({f[BLOCK_W+FOLD_SPAN-2:BLOCK_W], {BLOCK_W{1'b0}}});
      for (int i = 0; i < BLOCK_W; i++) begin
         z[BLOCK_W-1-i] = low[i];
      end
      return z;
   endfunction

endpackage

FILE: hw/rtl/ghash_acc_if.sv
// ----------------------------------------------------------------------------
// ghash_acc_if
// Valid/ready channels of the GHASH accumulator: request word and response word.
// ----------------------------------------------------------------------------
interface ghash_acc_req_if
   import ghash_acc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic                        opcode;
   logic [HALF_W-1:0]           block_high;
   logic [HALF_W-1:0]           block_low;
   logic [COUNT_W-1:0]          valid_bytes;

   modport source (output valid, output opcode, output block_high, output block_low,
                   output valid_bytes, input ready);
   modport sink   (input valid, input opcode, input block_high, input block_low,
                   input valid_bytes, output ready);
endinterface

interface ghash_acc_rsp_if
   import ghash_acc_pkg::*;
   ();
   logic                        valid;
   logic                        ready;
   logic [HALF_W-1:0]           hash_high;
   logic [HALF_W-1:0]           hash_low;

   modport source (output valid, output hash_high, output hash_low, input ready);
   modport sink   (input valid, input hash_high, input hash_low, output ready);
endinterface

FILE: hw/rtl/ghash_accumulator.sv
// ----------------------------------------------------------------------------
// ghash_accumulator
// GCM GHASH engine: absorbs masked 128-bit blocks and multiplies by subkey H.
// ----------------------------------------------------------------------------
// Each request word either absorbs a block (bytes past valid_bytes read as zero,
// the block is xored into the accumulator and the sum multiplied by H in
// GF(2^128)) or clears the accumulator. Every word returns the accumulator.
// A word is held in the input register, and the full 128x128 multiply and
// reduction run combinationally into the accumulator, also the response
// register. One word is taken every cycle unless the response is stalled;
// then one further word can wait in the input register. The user must write
// H through the csr port only while the engine is idle, unchecked by the block.
module ghash_accumulator
   import ghash_acc_pkg::*;
   (
   input  logic                    clock,
   input  logic                    reset,
   ghash_acc_req_if.sink           req_chan,
   ghash_acc_rsp_if.source         rsp_chan,
   input  logic                    csr_we,
   input  logic [CSR_IDX_W-1:0]    csr_index,
   input  logic [CSR_DATA_W-1:0]   csr_wdata
   );

   logic [HALF_W-1:0]  subkey_high_ff;
   logic [HALF_W-1:0]  subkey_low_ff;

   logic               s1_valid_ff, s1_valid_in;
   opcode_type         s1_op_ff, s1_op_in;
   block_type          s1_block_ff, s1_block_in;

   logic               rsp_valid_ff, rsp_valid_in;
   block_type          acc_ff, acc_in;

   logic               s1_adv;
   logic               req_take;
   block_type          raw_block;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         subkey_high_ff <= '0;
         subkey_low_ff  <= '0;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            REG_SUBKEY_HIGH: subkey_high_ff <= csr_wdata;
            REG_SUBKEY_LOW:  subkey_low_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // handshake
   assign s1_adv         = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready = !s1_valid_ff || s1_adv;
   assign req_take       = req_chan.valid && req_chan.ready;

   // input register with byte masking
   assign raw_block = {req_chan.block_high, req_chan.block_low};

   always_comb begin
      for (int k = 0; k < NBYTES; k++) begin
         s1_block_in[BLOCK_W-1-8*k -: 8] =
            (COUNT_W'(k) < req_chan.valid_bytes) ? raw_block[BLOCK_W-1-8*k -: 8] : 8'h00;
      end
      s1_op_in    = opcode_type'(req_chan.opcode);
      s1_valid_in = req_take || (s1_valid_ff && !s1_adv);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_op_ff    <= s1_op_in;
         s1_block_ff <= s1_block_in;
      end
   end

   // multiply into or clear the accumulator
   always_comb begin
      acc_in = acc_ff;
      if (s1_adv) begin
         case (s1_op_ff)
            OP_CLEAR:  acc_in = '0;
            OP_ABSORB: acc_in = gf128_mul(acc_ff ^ s1_block_ff, {subkey_high_ff, subkey_low_ff});
            default:   acc_in = '0;
         endcase
      end
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_chan.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_chan.valid     = rsp_valid_ff;
   assign rsp_chan.hash_high = acc_ff[BLOCK_W-1:HALF_W];
   assign rsp_chan.hash_low  = acc_ff[HALF_W-1:0];

   // checks
   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (s1_adv && s1_op_ff == OP_CLEAR) |=> (acc_ff == '0))
      else $error("accumulator not cleared");

   a_stall_holds_acc: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_chan.ready) |=> $stable(acc_ff))
      else $error("accumulator changed under stalled response");

   a_full_blocks_req: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && !s1_adv) |-> !req_chan.ready)
      else $error("request taken while input register full");

   a_adv_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      s1_adv |=> rsp_valid_ff)
      else $error("advanced word produced no response");

endmodule
